[hw/rtl/idfq_pkg.sv]
package idfq_pkg;

	localparam logic [1:0] CMD_ENQ    = 2'd0;
	localparam logic [1:0] CMD_DEQ    = 2'd1;
	localparam logic [1:0] CMD_FIND   = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] OFF_ZERO = 2'd0;
	localparam logic [1:0] OFF_ONE  = 2'd1;
	localparam logic [1:0] OFF_TWO  = 2'd2;

	typedef struct packed {
		logic       load_key;
		logic       wr_enq;
		logic       wr_shift;
		logic       rd_en;
		logic       rd_head;
		logic [1:0] rd_off;
		logic       idx_clr;
		logic       idx_inc;
		logic       pop;
		logic       shrink;
		logic       res_en;
		logic [1:0] res_status;
		logic       res_found;
		logic       res_data;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic hit;
		logic idx_last;
		logic next_last;
	} dp_stat_t;

endpackage

[hw/rtl/id_fifo_with_search_remove.sv]
// Enqueue completes from idle with no busy state; dequeue reads the head entry, then pops
// it. Dequeue, find and remove on an empty queue answer from idle. A search reads entries
// in turn over the single RAM read port; a remove moves each younger entry down a slot.
// busy is low again in the cycle done shows, so a new command can follow at once.
// done is a one-cycle strobe; the receiver cannot stall it.
// Reset clears the controller, head and occupancy; stored entries are left as they are.
module id_fifo_with_search_remove #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] id_value,
	output logic               done,
	output logic [1:0]         status,
	output logic               found,
	output logic signed [31:0] id_out
);

	import idfq_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t stat;

	idfq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.ctl   (ctl),
		.stat  (stat)
	);

	idfq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.id_value(id_value),
		.ctl     (ctl),
		.stat    (stat),
		.done    (done),
		.status  (status),
		.found   (found),
		.id_out  (id_out)
	);

endmodule

[hw/rtl/idfq_ram.sv]
module idfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/idfq_ctrl.sv]
module idfq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        cmd,
	output logic              busy,
	output idfq_pkg::ctl_cmd_t ctl,
	input  idfq_pkg::dp_stat_t stat
);

	import idfq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_DEQ   = 4'b0010,
		S_SCAN  = 4'b0100,
		S_SHIFT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   rm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rm_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				rm_q <= (cmd == CMD_REMOVE);
			end
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load_key = 1'b1;
					case (cmd)
						CMD_ENQ: begin
							ctl.res_en = 1'b1;
							if (stat.full) begin
								ctl.res_status = ST_FULL;
							end else begin
								ctl.wr_enq     = 1'b1;
								ctl.res_status = ST_OK;
							end
						end
						CMD_DEQ: begin
							if (stat.empty) begin
								ctl.res_en     = 1'b1;
								ctl.res_status = ST_EMPTY;
							end else begin
								ctl.rd_en   = 1'b1;
								ctl.rd_head = 1'b1;
								state_d     = S_DEQ;
							end
						end
						default: begin
							if (stat.empty) begin
								ctl.res_en     = 1'b1;
								ctl.res_status = ST_OK;
							end else begin
								ctl.rd_en   = 1'b1;
								ctl.rd_head = 1'b1;
								ctl.idx_clr = 1'b1;
								state_d     = S_SCAN;
							end
						end
					endcase
				end
			end
			S_DEQ: begin
				ctl.pop        = 1'b1;
				ctl.res_en     = 1'b1;
				ctl.res_status = ST_OK;
				ctl.res_data   = 1'b1;
				state_d        = S_IDLE;
			end
			S_SCAN: begin
				if (stat.hit) begin
					if (!rm_q || stat.idx_last) begin
						ctl.shrink     = rm_q;
						ctl.res_en     = 1'b1;
						ctl.res_status = ST_OK;
						ctl.res_found  = 1'b1;
						state_d        = S_IDLE;
					end else begin
						ctl.rd_en  = 1'b1;
						ctl.rd_off = OFF_ONE;
						state_d    = S_SHIFT;
					end
				end else if (stat.idx_last) begin
					ctl.res_en     = 1'b1;
					ctl.res_status = ST_OK;
					state_d        = S_IDLE;
				end else begin
					ctl.idx_inc = 1'b1;
					ctl.rd_en   = 1'b1;
					ctl.rd_off  = OFF_ONE;
				end
			end
			S_SHIFT: begin
				ctl.wr_shift = 1'b1;
				if (stat.next_last) begin
					ctl.shrink     = 1'b1;
					ctl.res_en     = 1'b1;
					ctl.res_status = ST_OK;
					ctl.res_found  = 1'b1;
					state_d        = S_IDLE;
				end else begin
					ctl.idx_inc = 1'b1;
					ctl.rd_en   = 1'b1;
					ctl.rd_off  = OFF_TWO;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/idfq_dp.sv]
module idfq_dp #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] id_value,
	input  idfq_pkg::ctl_cmd_t ctl,
	output idfq_pkg::dp_stat_t stat,
	output logic               done,
	output logic [1:0]         status,
	output logic               found,
	output logic signed [31:0] id_out
);

	import idfq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW+1:0] DEPTH_W = (AW+2)'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [31:0]   key_q;
	logic [31:0]   rdata;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic          we;
	logic          done_q;
	logic [1:0]    status_q;
	logic          found_q;
	logic [31:0]   id_out_q;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW+1:0] lidx);
		logic [AW+1:0] s;
		s = (AW+2)'(base) + lidx;
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	assign raddr = ctl.rd_head ? head_q
		: phys(head_q, (AW+2)'(idx_q) + (AW+2)'(ctl.rd_off));
	assign waddr = ctl.wr_enq ? phys(head_q, (AW+2)'(count_q))
		: phys(head_q, (AW+2)'(idx_q));
	assign wdata = ctl.wr_enq ? id_value : rdata;
	assign we    = ctl.wr_enq | ctl.wr_shift;

	idfq_ram #(
		.WIDTH(32),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctl.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign stat.full      = (count_q == CW'(QUEUE_DEPTH));
	assign stat.empty     = (count_q == '0);
	assign stat.hit       = (rdata == key_q);
	assign stat.idx_last  = ((AW+2)'(idx_q) + (AW+2)'(1)) == (AW+2)'(count_q);
	assign stat.next_last = ((AW+2)'(idx_q) + (AW+2)'(2)) == (AW+2)'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.res_en;
			if (ctl.wr_enq) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.pop || ctl.shrink) begin
				count_q <= count_q - CW'(1);
			end
			if (ctl.pop) begin
				head_q <= (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
			end
			if (ctl.idx_clr) begin
				idx_q <= '0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_key) begin
			key_q <= id_value;
		end
		if (ctl.res_en) begin
			status_q <= ctl.res_status;
			found_q  <= ctl.res_found;
			id_out_q <= ctl.res_data ? rdata : '0;
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign found  = found_q;
	assign id_out = id_out_q;

endmodule

[hw/rtl/idfq_chk.sv]
module idfq_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         cmd,
	input logic               done,
	input logic [1:0]         status,
	input logic               found,
	input logic signed [31:0] id_out
);

	import idfq_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
		else $error("reserved status code on transfer");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> !found && id_out == '0)
		else $error("failed command carries found or data");

	a_found_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> id_out == '0)
		else $error("search result carries data");

	a_enq_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_ENQ |=> done && !busy && !found && id_out == '0)
		else $error("enqueue did not complete in one cycle");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted command neither busy nor done");

endmodule

bind id_fifo_with_search_remove idfq_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.cmd     (cmd),
	.done    (done),
	.status  (status),
	.found   (found),
	.id_out  (id_out)
);
